// ----- hdl/angle_deficit_gaussian_curvature_macros.svh -----
// assertion macros used by the curvature back end module
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ANGLE_DEFICIT_GAUSSIAN_CURVATURE_MACROS_SVH
`define ANGLE_DEFICIT_GAUSSIAN_CURVATURE_MACROS_SVH

// condition implies consequence in the same cycle
`define ADG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ADG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/adg_pkg.sv -----
// types, constants and the arctangent table of the angle-deficit curvature block
// no dependencies
package adg_pkg;

    localparam int QUEUE_DEPTH = 2;

    // angles in Q2.30 radians
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    // 2*pi rounded half up to Q3.16
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [16:0] COS_ONE     = 17'h10000;

    typedef enum logic {
        REG_MIN_EDGE = 1'b0,
        REG_MIN_AREA = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic               last_triangle;
        logic               vertex_isolated;
    } t_item;

    typedef struct packed {
        logic signed [31:0] curvature;
        logic               saturated;
        logic               forced_zero;
    } t_result;

    // edge vectors of one triangle, as queued between front and back
    typedef struct packed {
        logic signed [32:0] e1_x;
        logic signed [32:0] e1_y;
        logic signed [32:0] e1_z;
        logic signed [32:0] e2_x;
        logic signed [32:0] e2_y;
        logic signed [32:0] e2_z;
        logic               last;
        logic               isolated;
    } t_tri;

    typedef struct packed {
        logic [15:0] min_edge_length;
        logic [15:0] min_area;
    } t_cfg;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/adg_front.sv -----
// front end: accepts items, forms the edge vectors e1 and e2 and queues them
// depends on adg_pkg
module adg_front #(
    parameter int DEPTH = adg_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  adg_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output adg_pkg::t_tri  o_tri
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    adg_pkg::t_tri    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    adg_pkg::t_tri    w_tri;
    logic             w_push_ok;
    logic             w_pop_ok;

    function automatic logic signed [32:0] edge_of(input logic signed [31:0] o,
                                                   input logic signed [31:0] c);
        return $signed({o[31], o}) - $signed({c[31], c});
    endfunction

    always_comb begin
        w_tri.e1_x     = edge_of(i_item.first_x,  i_item.center_x);
        w_tri.e1_y     = edge_of(i_item.first_y,  i_item.center_y);
        w_tri.e1_z     = edge_of(i_item.first_z,  i_item.center_z);
        w_tri.e2_x     = edge_of(i_item.second_x, i_item.center_x);
        w_tri.e2_y     = edge_of(i_item.second_y, i_item.center_y);
        w_tri.e2_z     = edge_of(i_item.second_z, i_item.center_z);
        w_tri.last     = i_item.last_triangle;
        w_tri.isolated = i_item.vertex_isolated;
    end

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_tri     = r_mem[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= w_tri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/adg_back.sv -----
// back end: per-triangle lengths, cosine, cordic angle, cross area, and the closing quotient
// one shared multiplier, one square root unit, one divider; depends on adg_pkg and the macros
`include "angle_deficit_gaussian_curvature_macros.svh"

module adg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  adg_pkg::t_cfg    i_cfg,
    input  logic             i_tri_valid,
    input  adg_pkg::t_tri    i_tri,
    output logic             o_tri_pop,
    input  logic             i_res_pop,
    output logic             o_res_valid,
    output adg_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_SQRT, S_DIV, S_CORDIC, S_FIN, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        P_LEN1, P_LEN2, P_DOT, P_DEN, P_SIN, P_CR0, P_CR1, P_CR2, P_AREA
    } t_phase;

    typedef enum logic [1:0] {SH_0, SH_27, SH_52} t_shift;

    t_state              r_state;
    t_phase              r_phase;
    logic [3:0]          r_idx;
    logic [5:0]          r_cnt;
    logic signed [32:0]  r_e1 [3];
    logic signed [32:0]  r_e2 [3];
    logic                r_last;
    logic                r_iso_seen;
    logic [32:0]         r_len1;
    logic [32:0]         r_len2;
    logic [65:0]         r_num;
    logic                r_neg;
    logic [16:0]         r_cm;
    logic [50:0]         r_cr [3];
    logic signed [67:0]  r_prod;
    logic signed [105:0] r_acc;
    logic [103:0]        r_rad;
    logic [55:0]         r_sq_rem;
    logic [51:0]         r_root;
    logic [66:0]         r_rem;
    logic [47:0]         r_dvd;
    logic [65:0]         r_dvs;
    logic [48:0]         r_quo;
    logic                r_div_final;
    logic                r_qneg;
    logic signed [33:0]  r_cx;
    logic signed [33:0]  r_cy;
    logic signed [32:0]  r_cz;
    logic [31:0]         r_angle_total;
    logic [63:0]         r_area_total;
    adg_pkg::t_result    r_pend;
    adg_pkg::t_result    r_res;
    logic                r_res_valid;

    // multiplier operand selection
    logic signed [33:0]  w_opa;
    logic signed [33:0]  w_opb;
    logic                w_sub;
    t_shift              w_sh;
    logic                w_last_op;
    logic [1:0]          w_i1;
    logic [1:0]          w_i2;
    logic [1:0]          w_grp;
    logic [1:0]          w_part;
    logic [50:0]         w_crv;
    logic signed [33:0]  w_hi;
    logic signed [33:0]  w_lo;

    logic signed [105:0] w_prod_ext;
    logic signed [105:0] w_term;
    logic signed [105:0] w_acc_next;
    logic [105:0]        w_acc_abs;

    logic [55:0]         w_sq_t;
    logic [55:0]         w_sq_trial;
    logic                w_sq_ge;
    logic [51:0]         w_root_next;
    logic [55:0]         w_sq_rem_next;
    logic [55:0]         w_root_x2;

    logic [67:0]         w_dt;
    logic [67:0]         w_dvs_ext;
    logic [67:0]         w_dt_sub;
    logic                w_dge;
    logic [66:0]         w_rem_next;
    logic [48:0]         w_quo_next;
    logic [66:0]         w_dvs67;

    logic signed [33:0]  w_xs;
    logic signed [33:0]  w_ys;
    logic signed [32:0]  w_atan;
    logic signed [33:0]  w_cx_next;
    logic signed [33:0]  w_cy_next;
    logic signed [32:0]  w_cz_next;
    logic [32:0]         w_z_cl;
    logic                w_mirror;
    logic [32:0]         w_th;
    logic [32:0]         w_th_rnd;
    logic [18:0]         w_angle;
    logic [32:0]         w_angle_sum;
    logic [31:0]         w_angle_new;

    logic [63:0]         w_area_inc;
    logic [64:0]         w_area_sum;
    logic [63:0]         w_area_new;

    logic                w_forced;
    logic signed [33:0]  w_fnum;
    logic [33:0]         w_fmag;
    adg_pkg::t_result    w_final;
    logic                w_len_ok;
    logic                w_commit;

    always_comb begin
        w_opa     = '0;
        w_opb     = '0;
        w_sub     = 1'b0;
        w_sh      = SH_0;
        w_last_op = 1'b0;
        w_i1      = 2'd0;
        w_i2      = 2'd0;
        w_grp     = 2'd0;
        w_part    = 2'd0;
        case (r_phase)
            P_CR0:   begin w_i1 = 2'd1; w_i2 = 2'd2; end
            P_CR1:   begin w_i1 = 2'd2; w_i2 = 2'd0; end
            P_CR2:   begin w_i1 = 2'd0; w_i2 = 2'd1; end
            default: begin w_i1 = 2'd0; w_i2 = 2'd0; end
        endcase
        case (r_idx)
            4'd0:    begin w_grp = 2'd0; w_part = 2'd0; end
            4'd1:    begin w_grp = 2'd0; w_part = 2'd1; end
            4'd2:    begin w_grp = 2'd0; w_part = 2'd2; end
            4'd3:    begin w_grp = 2'd1; w_part = 2'd0; end
            4'd4:    begin w_grp = 2'd1; w_part = 2'd1; end
            4'd5:    begin w_grp = 2'd1; w_part = 2'd2; end
            4'd6:    begin w_grp = 2'd2; w_part = 2'd0; end
            4'd7:    begin w_grp = 2'd2; w_part = 2'd1; end
            default: begin w_grp = 2'd2; w_part = 2'd2; end
        endcase
        w_crv = r_cr[w_grp];
        // split the 51-bit cross magnitude so each partial product fits the multiplier
        w_hi  = $signed({9'b0, w_crv[50:26]});
        w_lo  = $signed({8'b0, w_crv[25:0]});
        unique case (r_phase)
            P_LEN1: begin
                w_opa     = $signed({r_e1[r_idx[1:0]][32], r_e1[r_idx[1:0]]});
                w_opb     = w_opa;
                w_last_op = (r_idx == 4'd2);
            end
            P_LEN2: begin
                w_opa     = $signed({r_e2[r_idx[1:0]][32], r_e2[r_idx[1:0]]});
                w_opb     = w_opa;
                w_last_op = (r_idx == 4'd2);
            end
            P_DOT: begin
                w_opa     = $signed({r_e1[r_idx[1:0]][32], r_e1[r_idx[1:0]]});
                w_opb     = $signed({r_e2[r_idx[1:0]][32], r_e2[r_idx[1:0]]});
                w_last_op = (r_idx == 4'd2);
            end
            P_DEN: begin
                w_opa     = $signed({1'b0, r_len1});
                w_opb     = $signed({1'b0, r_len2});
                w_last_op = 1'b1;
            end
            P_SIN: begin
                w_opa     = $signed({17'b0, r_cm});
                w_opb     = w_opa;
                w_sub     = 1'b1;
                w_last_op = 1'b1;
            end
            P_CR0, P_CR1, P_CR2: begin
                if (r_idx[0]) begin
                    w_opa = $signed({r_e1[w_i2][32], r_e1[w_i2]});
                    w_opb = $signed({r_e2[w_i1][32], r_e2[w_i1]});
                end else begin
                    w_opa = $signed({r_e1[w_i1][32], r_e1[w_i1]});
                    w_opb = $signed({r_e2[w_i2][32], r_e2[w_i2]});
                end
                w_sub     = r_idx[0];
                w_last_op = (r_idx == 4'd1);
            end
            P_AREA: begin
                case (w_part)
                    2'd0:    begin w_opa = w_hi; w_opb = w_hi; w_sh = SH_52; end
                    2'd1:    begin w_opa = w_hi; w_opb = w_lo; w_sh = SH_27; end
                    default: begin w_opa = w_lo; w_opb = w_lo; w_sh = SH_0;  end
                endcase
                w_last_op = (r_idx == 4'd8);
            end
            default: begin
                w_last_op = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_prod_ext = $signed({{38{r_prod[67]}}, r_prod});
        case (w_sh)
            SH_27:   w_term = w_prod_ext <<< 27;
            SH_52:   w_term = w_prod_ext <<< 52;
            default: w_term = w_prod_ext;
        endcase
        w_acc_next = w_sub ? (r_acc - w_term) : (r_acc + w_term);
        w_acc_abs  = w_acc_next[105] ? $unsigned(-w_acc_next) : $unsigned(w_acc_next);
    end

    // restoring square root, one result bit per cycle
    always_comb begin
        w_sq_t        = {r_sq_rem[53:0], r_rad[103:102]};
        w_sq_trial    = {2'b00, r_root, 2'b01};
        w_sq_ge       = (w_sq_t >= w_sq_trial);
        w_root_next   = {r_root[50:0], w_sq_ge};
        w_sq_rem_next = w_sq_ge ? (w_sq_t - w_sq_trial) : w_sq_t;
        w_root_x2     = {3'b000, r_root, 1'b0};
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        w_dt       = {r_rem, r_dvd[47]};
        w_dvs_ext  = {2'b00, r_dvs};
        w_dge      = (w_dt >= w_dvs_ext);
        w_dt_sub   = w_dt - w_dvs_ext;
        w_rem_next = w_dge ? w_dt_sub[66:0] : w_dt[66:0];
        w_quo_next = {r_quo[47:0], w_dge};
        w_dvs67    = {1'b0, r_dvs};
    end

    // cordic vectoring step and angle finish
    always_comb begin
        w_xs   = r_cx >>> r_cnt[4:0];
        w_ys   = r_cy >>> r_cnt[4:0];
        w_atan = $signed({3'b000, adg_pkg::atan_q30(r_cnt[4:0])});
        if (!r_cy[33]) begin
            w_cx_next = r_cx + w_ys;
            w_cy_next = r_cy - w_xs;
            w_cz_next = r_cz + w_atan;
        end else begin
            w_cx_next = r_cx - w_ys;
            w_cy_next = r_cy + w_xs;
            w_cz_next = r_cz - w_atan;
        end
        if (w_cz_next[32]) begin
            w_z_cl = '0;
        end else if ($unsigned(w_cz_next) > adg_pkg::HALF_PI_Q30) begin
            w_z_cl = adg_pkg::HALF_PI_Q30;
        end else begin
            w_z_cl = $unsigned(w_cz_next);
        end
        // a zero cosine is not mirrored even when the dot product was negative
        w_mirror    = r_neg && (r_cm != '0);
        w_th        = w_mirror ? ({1'b0, adg_pkg::PI_Q30} - w_z_cl) : w_z_cl;
        w_th_rnd    = w_th + 33'd8192;
        w_angle     = w_th_rnd[32:14];
        w_angle_sum = {1'b0, r_angle_total} + {14'b0, w_angle};
        w_angle_new = w_angle_sum[32] ? 32'hFFFF_FFFF : w_angle_sum[31:0];
    end

    always_comb begin
        w_area_inc = {13'b0, w_root_next[51:1]};
        w_area_sum = {1'b0, r_area_total} + {1'b0, w_area_inc};
        w_area_new = w_area_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_area_sum[63:0];
        w_len_ok   = (r_len1 > {17'b0, i_cfg.min_edge_length})
                  && (w_root_next[32:0] > {17'b0, i_cfg.min_edge_length});
    end

    always_comb begin
        w_forced = r_iso_seen || (r_area_total == '0)
                || (r_area_total < {48'b0, i_cfg.min_area});
        w_fnum   = $signed({15'b0, adg_pkg::TWO_PI_Q16}) - $signed({2'b00, r_angle_total});
        w_fmag   = w_fnum[33] ? $unsigned(-w_fnum) : $unsigned(w_fnum);
        w_final.forced_zero = 1'b0;
        if (r_qneg) begin
            if (w_quo_next > 49'h0_8000_0000) begin
                w_final.curvature = 32'sh8000_0000;
                w_final.saturated = 1'b1;
            end else begin
                w_final.curvature = $signed(32'd0 - w_quo_next[31:0]);
                w_final.saturated = 1'b0;
            end
        end else begin
            if (w_quo_next > 49'h0_7FFF_FFFF) begin
                w_final.curvature = 32'sh7FFF_FFFF;
                w_final.saturated = 1'b1;
            end else begin
                w_final.curvature = $signed(w_quo_next[31:0]);
                w_final.saturated = 1'b0;
            end
        end
    end

    assign o_tri_pop   = (r_state == S_IDLE) && i_tri_valid;
    assign w_commit    = (r_state == S_OUT) && (!r_res_valid || i_res_pop);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= P_LEN1;
            r_idx         <= '0;
            r_cnt         <= '0;
            r_iso_seen    <= 1'b0;
            r_angle_total <= '0;
            r_area_total  <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            if (i_res_pop && r_res_valid && !w_commit) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_e1[0] <= i_tri.e1_x;
                        r_e1[1] <= i_tri.e1_y;
                        r_e1[2] <= i_tri.e1_z;
                        r_e2[0] <= i_tri.e2_x;
                        r_e2[1] <= i_tri.e2_y;
                        r_e2[2] <= i_tri.e2_z;
                        r_last  <= i_tri.last;
                        r_phase <= P_LEN1;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        if (i_tri.isolated) begin
                            r_iso_seen <= 1'b1;
                            r_state    <= S_FIN;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_opa * w_opb;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!w_last_op) begin
                        r_acc   <= w_acc_next;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_idx <= '0;
                        unique case (r_phase)
                            P_LEN1, P_LEN2, P_SIN, P_AREA: begin
                                r_rad    <= w_acc_next[103:0];
                                r_sq_rem <= '0;
                                r_root   <= '0;
                                r_cnt    <= '0;
                                r_state  <= S_SQRT;
                            end
                            P_DOT: begin
                                r_neg   <= w_acc_next[105];
                                r_num   <= w_acc_abs[65:0];
                                r_acc   <= '0;
                                r_phase <= P_DEN;
                                r_state <= S_MUL;
                            end
                            P_DEN: begin
                                if (r_num >= w_acc_next[65:0]) begin
                                    r_cm    <= adg_pkg::COS_ONE;
                                    r_acc   <= 106'sh1_0000_0000;
                                    r_phase <= P_SIN;
                                    r_state <= S_MUL;
                                end else begin
                                    r_rem       <= {1'b0, r_num};
                                    r_dvd       <= '0;
                                    r_dvs       <= w_acc_next[65:0];
                                    r_quo       <= '0;
                                    r_cnt       <= '0;
                                    r_div_final <= 1'b0;
                                    r_state     <= S_DIV;
                                end
                            end
                            P_CR0: begin
                                r_cr[0] <= w_acc_abs[66:16];
                                r_acc   <= '0;
                                r_phase <= P_CR1;
                                r_state <= S_MUL;
                            end
                            P_CR1: begin
                                r_cr[1] <= w_acc_abs[66:16];
                                r_acc   <= '0;
                                r_phase <= P_CR2;
                                r_state <= S_MUL;
                            end
                            P_CR2: begin
                                r_cr[2] <= w_acc_abs[66:16];
                                r_acc   <= '0;
                                r_phase <= P_AREA;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    r_sq_rem <= w_sq_rem_next;
                    r_root   <= w_root_next;
                    r_rad    <= {r_rad[101:0], 2'b00};
                    // the count restarts at the last step so the cordic begins at zero
                    r_cnt    <= (r_cnt == 6'd51) ? '0 : r_cnt + 1'b1;
                    if (r_cnt == 6'd51) begin
                        r_acc <= '0;
                        r_idx <= '0;
                        unique case (r_phase)
                            P_LEN1: begin
                                r_len1  <= w_root_next[32:0];
                                r_phase <= P_LEN2;
                                r_state <= S_MUL;
                            end
                            P_LEN2: begin
                                r_len2  <= w_root_next[32:0];
                                r_phase <= w_len_ok ? P_DOT : P_CR0;
                                r_state <= S_MUL;
                            end
                            P_SIN: begin
                                r_cx    <= $signed({3'b000, r_cm, 14'b0});
                                r_cy    <= $signed({3'b000, w_root_next[16:0], 14'b0});
                                r_cz    <= '0;
                                r_state <= S_CORDIC;
                            end
                            P_AREA: begin
                                r_area_total <= w_area_new;
                                r_state      <= S_FIN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= w_quo_next;
                    r_dvd <= {r_dvd[46:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (!r_div_final && (r_cnt == 6'd15)) begin
                        r_cm    <= w_quo_next[16:0];
                        r_acc   <= 106'sh1_0000_0000;
                        r_idx   <= '0;
                        r_phase <= P_SIN;
                        r_state <= S_MUL;
                    end else if (r_div_final && (r_cnt == 6'd47)) begin
                        r_pend  <= w_final;
                        r_state <= S_OUT;
                    end
                end
                S_CORDIC: begin
                    r_cx  <= w_cx_next;
                    r_cy  <= w_cy_next;
                    r_cz  <= w_cz_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd29) begin
                        r_angle_total <= w_angle_new;
                        r_acc         <= '0;
                        r_idx         <= '0;
                        r_phase       <= P_CR0;
                        r_state       <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (w_forced) begin
                        r_pend.curvature   <= '0;
                        r_pend.saturated   <= 1'b0;
                        r_pend.forced_zero <= 1'b1;
                        r_state            <= S_OUT;
                    end else begin
                        r_rem       <= '0;
                        r_dvd       <= {w_fmag[31:0], 16'b0};
                        r_dvs       <= {2'b00, r_area_total};
                        r_quo       <= '0;
                        r_cnt       <= '0;
                        r_qneg      <= w_fnum[33];
                        r_div_final <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_OUT: begin
                    if (w_commit) begin
                        r_res         <= r_pend;
                        r_res_valid   <= 1'b1;
                        r_angle_total <= '0;
                        r_area_total  <= '0;
                        r_iso_seen    <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ADG_ASSERT_IMPLIES(a_sqrt_rem_bound, r_state == S_SQRT, r_sq_rem <= w_root_x2, "sqrt remainder above twice the root")
    `ADG_ASSERT_IMPLIES(a_div_rem_bound, r_state == S_DIV, r_rem < w_dvs67, "divider remainder not below divisor")
    `ADG_ASSERT_IMPLIES(a_cordic_x_pos, r_state == S_CORDIC, !r_cx[33], "cordic x went negative")
    `ADG_ASSERT_NEXT(a_sums_clear, w_commit, (r_angle_total == '0) && (r_area_total == '0) && !r_iso_seen, "sums not cleared after result")

endmodule

// ----- hdl/angle_deficit_gaussian_curvature.sv -----
// the angle is skipped when an edge is no longer than min_edge_length; isolated triangles go
// straight to the finish; the last triangle may add the closing quotient; one triangle in work at a time
// the one-bit-per-cycle square root unit (52 steps, up to four uses per triangle) sets the pace
// queue between front and back holds QUEUE_DEPTH triangles; result register frees the back end
// synchronous active-low reset clears sums, queue and result; thresholds reset to 1
module angle_deficit_gaussian_curvature #(
    parameter int QUEUE_DEPTH = adg_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             push,
    output logic             full,
    input  adg_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output adg_pkg::t_result o_result
);

    logic [15:0]       r_min_edge;
    logic [15:0]       r_min_area;
    adg_pkg::t_cfg     w_cfg;
    adg_pkg::t_reg_idx w_reg;
    logic              w_cfg_wr;
    logic              w_tri_valid;
    logic              w_tri_pop;
    adg_pkg::t_tri     w_tri;
    logic              w_res_valid;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = adg_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (w_reg)
            adg_pkg::REG_MIN_EDGE: prdata = {16'b0, r_min_edge};
            adg_pkg::REG_MIN_AREA: prdata = {16'b0, r_min_area};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_edge <= 16'd1;
            r_min_area <= 16'd1;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                adg_pkg::REG_MIN_EDGE: r_min_edge <= pwdata[15:0];
                adg_pkg::REG_MIN_AREA: r_min_area <= pwdata[15:0];
                default:               r_min_edge <= r_min_edge;
            endcase
        end
    end

    assign w_cfg.min_edge_length = r_min_edge;
    assign w_cfg.min_area        = r_min_area;

    adg_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (w_tri_pop),
        .o_valid (w_tri_valid),
        .o_tri   (w_tri)
    );

    adg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_tri_valid (w_tri_valid),
        .i_tri       (w_tri),
        .o_tri_pop   (w_tri_pop),
        .i_res_pop   (pop),
        .o_res_valid (w_res_valid),
        .o_result    (o_result)
    );

    assign empty = !w_res_valid;

endmodule
